// ===== sv/isrch_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the interpolation search block.
package isrch_pkg;

    localparam int ELEM_W  = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [INDEX_W-1:0]       index;
        logic signed [ELEM_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] position;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_RD_LOW,
        ST_RD_HIGH,
        ST_DIVIDE,
        ST_RD_POS_ADDR,
        ST_RD_POS,
        ST_FINISH
    } search_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_RUN
    } div_state_t;

endpackage

// ===== sv/isrch_mem.sv =====
`timescale 1ns / 1ps
// Element store: one write port, one read port with registered read data.
module isrch_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [AW-1:0]                        waddr,
    input  logic signed [isrch_pkg::ELEM_W-1:0]  wdata,
    input  logic [AW-1:0]                        raddr,
    output logic signed [isrch_pkg::ELEM_W-1:0]  rdata
);

    logic signed [isrch_pkg::ELEM_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/isrch_div.sv =====
`timescale 1ns / 1ps
// Probe offset unit: floor(a * b / den), one registered multiply then AW restoring steps.
module isrch_div #(
    parameter int AW = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [isrch_pkg::ELEM_W-1:0]    a,
    input  logic [AW-1:0]                   b,
    input  logic [isrch_pkg::ELEM_W-1:0]    den,
    output logic                            done,
    output logic [AW-1:0]                   quot
);

    localparam int EW = isrch_pkg::ELEM_W;
    localparam int NW = EW + AW;
    localparam int CW = $clog2(AW + 1);

    isrch_pkg::div_state_t state_reg, state_next;

    logic [EW-1:0] a_reg, a_next;
    logic [AW-1:0] b_reg, b_next;
    logic [EW-1:0] den_reg, den_next;
    logic [EW-1:0] rem_reg, rem_next;
    logic [AW-1:0] bits_reg, bits_next;
    logic [CW-1:0] step_reg, step_next;

    logic [NW-1:0] prod;
    logic [EW:0]   trial;
    logic          qbit;
    logic [AW:0]   shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isrch_pkg::DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        step_reg <= step_next;
    end

    // Quotient is known to fit AW bits, so the upper product bits start below den.
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        step_next  = step_reg;
        done       = 1'b0;
        prod       = a_reg * b_reg;
        trial      = {rem_reg, bits_reg[AW-1]};
        qbit       = (trial >= {1'b0, den_reg});
        shifted    = {bits_reg, qbit};

        case (state_reg)
            isrch_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    a_next     = a;
                    b_next     = b;
                    den_next   = den;
                    state_next = isrch_pkg::DIV_MUL;
                end
            end
            isrch_pkg::DIV_MUL:
            begin
                rem_next   = prod[NW-1:AW];
                bits_next  = prod[AW-1:0];
                step_next  = CW'(AW);
                state_next = isrch_pkg::DIV_RUN;
            end
            isrch_pkg::DIV_RUN:
            begin
                if (step_reg == '0)
                begin
                    done       = 1'b1;
                    state_next = isrch_pkg::DIV_IDLE;
                end
                else
                begin
                    if (qbit)
                    begin
                        rem_next = EW'(trial - {1'b0, den_reg});
                    end
                    else
                    begin
                        rem_next = trial[EW-1:0];
                    end
                    bits_next = shifted[AW-1:0];
                    step_next = step_reg - CW'(1);
                end
            end
            default:
            begin
                state_next = isrch_pkg::DIV_IDLE;
            end
        endcase
    end

    assign quot = bits_reg;

endmodule

// ===== sv/interpolation_search.sv =====
`timescale 1ns / 1ps
// A load item is written to the store when accepted. Each search probe reads the store in
// the loop, low-read, high-read, probe-address and probe states, stopping after the high read
// when the key leaves the bracket, and runs the multiply/divide unit before the probe address
// unless the bound values are equal (AW = clog2(DEPTH)). Crossed bounds go from the loop state
// to finish, which registers the result once the output slot is free. One item at a time.
// Reset clears count_reg and control state; the store holds no reset value.
module interpolation_search #(
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  isrch_pkg::in_item_t              in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output isrch_pkg::out_item_t             out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [isrch_pkg::COUNT_W-1:0]    cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = AW + 2;
    localparam int EW = isrch_pkg::ELEM_W;

    isrch_pkg::search_state_t state_reg, state_next;

    logic [isrch_pkg::COUNT_W-1:0] count_reg, count_next;
    logic signed [EW-1:0]          key_reg, key_next;
    logic signed [EW-1:0]          dl_reg, dl_next;
    logic signed [PW-1:0]          low_reg, low_next;
    logic signed [PW-1:0]          high_reg, high_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic                          found_reg, found_next;
    logic                          out_valid_reg, out_valid_next;
    isrch_pkg::out_item_t          out_item_reg, out_item_next;

    logic                          mem_we;
    logic [AW-1:0]                 rd_addr;
    logic signed [EW-1:0]          rdata;

    logic                          div_start;
    logic                          div_done;
    logic [EW-1:0]                 div_a;
    logic [AW-1:0]                 div_b;
    logic [EW-1:0]                 div_den;
    logic [AW-1:0]                 div_q;

    logic signed [PW-1:0]          count_lim;
    logic signed [PW-1:0]          span_full;
    logic signed [PW-1:0]          pos_ext;
    logic [EW:0]                   diff_full;
    logic [EW:0]                   den_full;
    logic                          in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == isrch_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign mem_we = in_accept && (in_item.op == isrch_pkg::OP_LOAD)
                    && (32'(in_item.index) < 32'(DEPTH));

    isrch_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(in_item.index)),
        .wdata (in_item.value),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    isrch_div #(
        .AW (AW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign count_lim = (32'(count_reg) > 32'(DEPTH)) ? PW'(DEPTH) : PW'(count_reg);
    assign span_full = high_reg - low_reg;
    assign pos_ext   = $signed({2'b00, pos_reg});
    // Key sits inside the bracket here, so both differences are non-negative 32-bit values.
    assign diff_full = {key_reg[EW-1], key_reg} - {dl_reg[EW-1], dl_reg};
    assign den_full  = {rdata[EW-1], rdata} - {dl_reg[EW-1], dl_reg};
    assign div_a     = diff_full[EW-1:0];
    assign div_b     = span_full[AW-1:0];
    assign div_den   = den_full[EW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isrch_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        dl_reg       <= dl_next;
        low_reg      <= low_next;
        high_reg     <= high_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        dl_next        = dl_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        rd_addr        = low_reg[AW-1:0];
        div_start      = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            isrch_pkg::ST_IDLE:
            begin
                if (in_accept && (in_item.op == isrch_pkg::OP_SEARCH))
                begin
                    key_next   = in_item.value;
                    low_next   = '0;
                    high_next  = count_lim - PW'(1);
                    found_next = 1'b0;
                    state_next = isrch_pkg::ST_LOOP;
                end
            end
            isrch_pkg::ST_LOOP:
            begin
                rd_addr = low_reg[AW-1:0];
                if (low_reg > high_reg)
                begin
                    state_next = isrch_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = isrch_pkg::ST_RD_LOW;
                end
            end
            isrch_pkg::ST_RD_LOW:
            begin
                dl_next    = rdata;
                rd_addr    = high_reg[AW-1:0];
                state_next = isrch_pkg::ST_RD_HIGH;
            end
            isrch_pkg::ST_RD_HIGH:
            begin
                if (!((dl_reg <= key_reg) && (key_reg <= rdata)))
                begin
                    state_next = isrch_pkg::ST_FINISH;
                end
                else if (rdata == dl_reg)
                begin
                    pos_next   = low_reg[AW-1:0];
                    state_next = isrch_pkg::ST_RD_POS_ADDR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = isrch_pkg::ST_DIVIDE;
                end
            end
            isrch_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    pos_next   = low_reg[AW-1:0] + div_q;
                    state_next = isrch_pkg::ST_RD_POS_ADDR;
                end
            end
            isrch_pkg::ST_RD_POS_ADDR:
            begin
                rd_addr    = pos_reg;
                state_next = isrch_pkg::ST_RD_POS;
            end
            isrch_pkg::ST_RD_POS:
            begin
                if (rdata == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = isrch_pkg::ST_FINISH;
                end
                else if (rdata < key_reg)
                begin
                    low_next   = pos_ext + PW'(1);
                    state_next = isrch_pkg::ST_LOOP;
                end
                else
                begin
                    high_next  = pos_ext - PW'(1);
                    state_next = isrch_pkg::ST_LOOP;
                end
            end
            isrch_pkg::ST_FINISH:
            begin
                // Wait for the output slot to free up.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.found    = found_reg;
                    out_item_next.position = found_reg ? isrch_pkg::INDEX_W'(pos_reg) : '0;
                    state_next             = isrch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isrch_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/interpolation_search_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for interpolation_search: loads, searches and count settings.
module interpolation_search_test;
    import isrch_pkg::*;

    localparam int DEPTH = 1024;
    // worst search: about 1024 probes
    localparam int STALL_LIMIT = 100000;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

    typedef enum int {
        FILL_SPREAD,
        FILL_FULL_RANGE,
        FILL_SKEWED,
        FILL_FLAT,
        FILL_SHUFFLED
    } fill_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    in_item_t           in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;

    // our copy of the store and the element count
    logic signed [ELEM_W-1:0] elem_mirror [DEPTH];
    logic [COUNT_W-1:0]       elem_count = '0;
    // array to be loaded in the next phase
    logic signed [ELEM_W-1:0] plan [DEPTH];

    out_item_t lookup_expected [$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        stall_cycles = 0;
    bit        quiet = 1'b0;

    interpolation_search #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic out_item_t predict_lookup(input logic signed [ELEM_W-1:0] key);
        out_item_t res;
        longint    k;
        longint    lo;
        longint    hi;
        longint    dl;
        longint    dh;
        longint    dp;
        longint    pos;
        bit        done;
        res  = '0;
        k    = key;
        lo   = 0;
        done = 1'b0;
        if (elem_count > DEPTH)
            hi = DEPTH - 1;
        else
            hi = longint'(elem_count) - 1;
        while (!done && lo <= hi)
        begin
            dl = elem_mirror[lo];
            dh = elem_mirror[hi];
            if (k < dl || k > dh)
            begin
                done = 1'b1;
            end
            else
            begin
                // equal bound values: probe low, no division
                if (dh == dl)
                    pos = lo;
                else
                    pos = lo + (k - dl) * (hi - lo) / (dh - dl);
                dp = elem_mirror[pos];
                if (dp == k)
                begin
                    res.found    = 1'b1;
                    res.position = pos[INDEX_W-1:0];
                    done         = 1'b1;
                end
                else if (dp < k)
                begin
                    lo = pos + 1;
                end
                else
                begin
                    hi = pos - 1;
                end
            end
        end
        return res;
    endfunction

    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic signed [ELEM_W-1:0] val);
        in_item_t item;
        item.op    = op;
        item.index = idx;
        item.value = val;
        if (!quiet)
        begin
            while ($urandom_range(99) < 22)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == OP_LOAD)
            elem_mirror[idx] = val;
        else
            lookup_expected.push_back(predict_lookup(val));
        items_sent++;
    endtask

    // wait out outstanding searches, then give a trailing load time to land
    task automatic drain();
        in_valid <= 1'b0;
        while (lookup_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_count(input logic [COUNT_W-1:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        elem_count = n;
    endtask

    task automatic build_plan(input int n, input fill_mode_t mode);
        longint          v;
        longint unsigned stride;
        int              sh;
        sh     = $urandom_range(24);
        v      = $signed($urandom);
        stride = 64'd2 * (64'hffff_ffff / n);
        if (stride > 64'hffff_ffff)
            stride = 64'hffff_ffff;
        if (mode == FILL_FULL_RANGE)
            v = ELEM_MIN;
        else if (mode == FILL_SKEWED)
            v = int'($urandom_range(2000)) - 1000;
        for (int i = 0; i < n; i++)
        begin
            if (mode == FILL_SHUFFLED)
                v = int'($urandom_range(2 * n)) - n;
            if (v > ELEM_MAX)
                v = ELEM_MAX;
            plan[i] = ELEM_W'(v);
            case (mode)
                FILL_SPREAD:     v += $urandom_range(32'd1 << sh);
                FILL_FULL_RANGE: v += $urandom_range(stride);
                FILL_SKEWED:     v += (64'd1 << (i * 31 / n)) + $urandom_range(3);
                default:         v = v;
            endcase
        end
        if (mode == FILL_FULL_RANGE)
            plan[n - 1] = ELEM_MAX;
    endtask

    // loads entries 0..n-1, starting at a random point and wrapping
    task automatic load_plan(input int n);
        int rot;
        rot = $urandom_range(n - 1);
        for (int i = 0; i < n; i++)
            send_item(OP_LOAD, INDEX_W'((i + rot) % n), plan[(i + rot) % n]);
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_key(input int n);
        int i;
        i = $urandom_range(n - 1);
        case ($urandom_range(9))
            0, 1, 2, 3: return elem_mirror[i];
            4:          return elem_mirror[i] + 1;
            5:          return elem_mirror[i] - 1;
            6:          return ELEM_MIN;
            7:          return ELEM_MAX;
            default:    return $urandom;
        endcase
    endfunction

    // count is zero after reset: every search misses without reading the store
    task automatic test_empty_store();
        send_item(OP_SEARCH, '0, ELEM_MIN);
        send_item(OP_SEARCH, '1, ELEM_MAX);
        send_item(OP_SEARCH, '0, 0);
    endtask

    task automatic test_directed();
        plan[0] = ELEM_MIN;
        plan[1] = -1000;
        plan[2] = 0;
        plan[3] = 0;
        plan[4] = 77;
        plan[5] = ELEM_MAX;
        load_plan(6);
        set_count(6);
        send_item(OP_SEARCH, '0, ELEM_MIN);
        send_item(OP_SEARCH, '1, ELEM_MAX);
        send_item(OP_SEARCH, '0, 0);
        send_item(OP_SEARCH, '0, 77);
        send_item(OP_SEARCH, '0, 76);
        send_item(OP_SEARCH, '0, 1);
        // single element
        set_count(1);
        send_item(OP_SEARCH, '1, ELEM_MIN);
        send_item(OP_SEARCH, '1, ELEM_MIN + 1);
        // all values equal
        plan[0] = 42;
        plan[1] = 42;
        plan[2] = 42;
        load_plan(3);
        set_count(3);
        send_item(OP_SEARCH, '0, 42);
        send_item(OP_SEARCH, '0, 43);
        send_item(OP_SEARCH, '0, 41);
        set_count(0);
        send_item(OP_SEARCH, '0, 42);
    endtask

    task automatic test_random_phases(input int item_target);
        int         n;
        fill_mode_t mode;
        while (items_sent < item_target)
        begin
            if ($urandom_range(9) == 0)
                n = $urandom_range(200, 65);
            else
                n = $urandom_range(48, 1);
            mode = fill_mode_t'($urandom_range(4));
            build_plan(n, mode);
            load_plan(n);
            set_count(COUNT_W'(n));
            repeat ($urandom_range(30, 8))
            begin
                // stray loads may land inside the array and unsort it
                if ($urandom_range(9) == 0)
                    send_item(OP_LOAD, INDEX_W'($urandom), $urandom);
                else
                    send_item(OP_SEARCH, INDEX_W'($urandom), pick_key(n));
            end
        end
    endtask

    task automatic test_full_depth();
        build_plan(DEPTH, FILL_FULL_RANGE);
        load_plan(DEPTH);
        set_count(COUNT_W'(DEPTH));
        repeat (12) send_item(OP_SEARCH, INDEX_W'($urandom), pick_key(DEPTH));
        // counts above the depth are clipped
        set_count('1);
        repeat (6) send_item(OP_SEARCH, INDEX_W'($urandom), pick_key(DEPTH));
        set_count(COUNT_W'(DEPTH + 1));
        repeat (3) send_item(OP_SEARCH, INDEX_W'($urandom), pick_key(DEPTH));
        set_count(0);
        send_item(OP_SEARCH, INDEX_W'($urandom), pick_key(DEPTH));
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (lookup_expected.size() == 0)
                begin
                    $error("unexpected item: found=%0b position=%0d",
                           out_item.found, out_item.position);
                    fail_count++;
                end
                else
                begin
                    want = lookup_expected.pop_front();
                    if (out_item.found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, out_item.found);
                        fail_count++;
                    end
                    if (out_item.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, out_item.position);
                        fail_count++;
                    end
                end
            end
            out_ready <= quiet || ($urandom_range(99) >= 22);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("interpolation_search_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_directed();
        test_random_phases(200);
        quiet = 1'b1;
        test_random_phases(260);
        quiet = 1'b0;
        test_full_depth();
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("interpolation_search_test: PASS");
        else
            $display("interpolation_search_test: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/isrch_pkg.sv
sv/isrch_mem.sv
sv/isrch_div.sv
sv/interpolation_search.sv
sim/interpolation_search_test.sv
